// ----- hw/rtl/crc8wd_pkg.sv -----
// Shared types, constants and the CRC-8 byte step for the word response deframer.
// Used by the front end, back end and top level in hw/rtl; depends on nothing.
`default_nettype none

package crc8wd_pkg;

  localparam logic [7:0]  CrcPoly   = 8'h31;
  localparam logic [7:0]  CrcInit   = 8'hFF;
  localparam logic [15:0] ReadyMask = 16'h07FF;
  localparam logic [14:0] TempCoeff = 15'd17500;
  localparam logic [14:0] HumCoeff  = 15'd10000;
  localparam logic [16:0] TempBias  = 17'd4500;

  // Response kinds
  localparam logic [1:0] KindSerial = 2'd0;
  localparam logic [1:0] KindReady  = 2'd1;
  localparam logic [1:0] KindMeas   = 2'd2;

  // Register indexes
  localparam logic RegKind = 1'b0;

  // Byte positions within a word frame
  localparam logic [1:0] PosHigh = 2'd0;
  localparam logic [1:0] PosLow  = 2'd1;
  localparam logic [1:0] PosCrc  = 2'd2;

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_TEMP  = 2'd1,
    OP_HUMID = 2'd2,
    OP_FAIL  = 2'd3
  } op_e;

  // Classified word passed from front to back
  typedef struct packed {
    logic [15:0] data_word;
    logic [1:0]  word_index;
    logic        crc_ok;
    logic        last_word;
    logic        data_ready;
    op_e         op;
  } rec_t;

  // Finished result
  typedef struct packed {
    logic [15:0]        data_word;
    logic [1:0]         word_index;
    logic               crc_ok;
    logic               last_word;
    logic signed [16:0] scaled_value;
    logic               data_ready;
  } res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] words_for_kind(input logic [1:0] kind);
    return (kind == KindReady) ? 3'd1 : 3'd3;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crc8wd_fifo.sv -----
// Small first-in first-out queue of registers with a fill count.
// Generic; no package dependency.
`default_nettype none

module crc8wd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/crc8wd_front.sv -----
// Front end: takes bytes, tracks framing and CRC, classifies each finished word.
// Depends on crc8wd_pkg.
`default_nettype none

module crc8wd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       kind_i,
  input  wire logic             accept_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             first_byte_i,
  output logic                  rec_valid_o,
  output crc8wd_pkg::rec_t      rec_o
);

  logic [1:0] pos_q, pos_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic       disc_q, disc_d;

  logic [1:0]  eff_pos, eff_cnt;
  logic [7:0]  eff_crc, crc_next;
  logic        eff_disc, ok, last;
  logic [15:0] word;

  assign eff_pos  = first_byte_i ? crc8wd_pkg::PosHigh : pos_q;
  assign eff_cnt  = first_byte_i ? 2'd0 : cnt_q;
  assign eff_crc  = first_byte_i ? crc8wd_pkg::CrcInit : crc_q;
  assign eff_disc = first_byte_i ? 1'b0 : disc_q;
  assign crc_next = crc8wd_pkg::crc8_byte(eff_crc, rx_byte_i);
  assign word     = {high_q, low_q};
  assign ok       = (eff_crc == rx_byte_i);
  assign last     = !ok || (({1'b0, eff_cnt} + 3'd1) >= crc8wd_pkg::words_for_kind(kind_i));

  always_comb begin
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    high_d      = high_q;
    low_d       = low_q;
    disc_d      = disc_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    if (accept_i) begin
      pos_d  = eff_pos;
      cnt_d  = eff_cnt;
      crc_d  = eff_crc;
      disc_d = eff_disc;
      if (!eff_disc) begin
        case (eff_pos)
          crc8wd_pkg::PosLow: begin
            crc_d = crc_next;
            low_d = rx_byte_i;
            pos_d = crc8wd_pkg::PosCrc;
          end
          crc8wd_pkg::PosCrc: begin
            rec_valid_o      = 1'b1;
            rec_o.data_word  = word;
            rec_o.word_index = eff_cnt;
            rec_o.crc_ok     = ok;
            rec_o.last_word  = last;
            rec_o.data_ready = ok && (kind_i == crc8wd_pkg::KindReady)
                               && ((word & crc8wd_pkg::ReadyMask) != 16'd0);
            if (!ok) begin
              rec_o.op = crc8wd_pkg::OP_FAIL;
            end else if (kind_i == crc8wd_pkg::KindMeas && eff_cnt == 2'd1) begin
              rec_o.op = crc8wd_pkg::OP_TEMP;
            end else if (kind_i == crc8wd_pkg::KindMeas && eff_cnt == 2'd2) begin
              rec_o.op = crc8wd_pkg::OP_HUMID;
            end else begin
              rec_o.op = crc8wd_pkg::OP_RAW;
            end
            if (ok) begin
              cnt_d = eff_cnt + 2'd1;
            end
            disc_d = last;
            crc_d  = crc8wd_pkg::CrcInit;
            pos_d  = crc8wd_pkg::PosHigh;
          end
          default: begin
            // high byte of a word
            crc_d  = crc_next;
            high_d = rx_byte_i;
            pos_d  = crc8wd_pkg::PosLow;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= crc8wd_pkg::PosHigh;
      cnt_q  <= 2'd0;
      crc_q  <= crc8wd_pkg::CrcInit;
      high_q <= 8'd0;
      low_q  <= 8'd0;
      disc_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      high_q <= high_d;
      low_q  <= low_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/crc8wd_back.sv -----
// Back end: multiplies the word by its scale factor, then finishes the result.
// Depends on crc8wd_pkg.
`default_nettype none

module crc8wd_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         rec_valid_i,
  input  wire crc8wd_pkg::rec_t rec_i,
  output logic              rec_pop_o,
  input  wire logic         res_full_i,
  output logic              res_push_o,
  output crc8wd_pkg::res_t  res_o
);

  logic             s1_valid_q, s1_valid_d;
  crc8wd_pkg::rec_t s1_rec_q;
  logic [30:0]      prod_q;
  logic [14:0]      coeff;
  logic             load;
  logic [16:0]      frac;

  assign res_push_o = s1_valid_q && !res_full_i;
  assign load       = rec_valid_i && (!s1_valid_q || res_push_o);
  assign rec_pop_o  = load;
  assign coeff      = (rec_i.op == crc8wd_pkg::OP_TEMP) ? crc8wd_pkg::TempCoeff
                                                        : crc8wd_pkg::HumCoeff;
  assign frac       = {2'b00, prod_q[30:16]};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (res_push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_o.data_word  = s1_rec_q.data_word;
    res_o.word_index = s1_rec_q.word_index;
    res_o.crc_ok     = s1_rec_q.crc_ok;
    res_o.last_word  = s1_rec_q.last_word;
    res_o.data_ready = s1_rec_q.data_ready;
    case (s1_rec_q.op)
      crc8wd_pkg::OP_RAW:   res_o.scaled_value = {1'b0, s1_rec_q.data_word};
      crc8wd_pkg::OP_TEMP:  res_o.scaled_value = frac - crc8wd_pkg::TempBias;
      crc8wd_pkg::OP_HUMID: res_o.scaled_value = frac;
      default:              res_o.scaled_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_rec_q <= rec_i;
      prod_q   <= 31'(coeff) * 31'(rec_i.data_word);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/crc8_word_response_deframer.sv -----
// Top level of the CRC-8 word response deframer.
// Depends on crc8wd_pkg, crc8wd_front, crc8wd_fifo and crc8wd_back.
//
// Usage:
//   Input channel: drive rx_byte_i and first_byte_i with push high; a byte is
//   taken at a clock edge with push high and full low. Mark the first byte of
//   each response with first_byte_i. Bytes are 2-byte big-endian words, each
//   followed by its CRC-8 (poly 0x31, init 0xFF).
//   Result channel: while empty is low the oldest result is on the result
//   ports; pulse pop to take it. One result appears per checksum byte that is not dropped after a response ends.
//   Throughput: one byte per cycle, sustained, while results are drained.
//   Path: after its checksum byte is taken, a result passes front classify,
//   word queue, one multiply stage and result queue to the ports.
//   Config: APB register 0 (byte address 0) holds response_kind; write only
//   while the block is idle.
//   Reset: framing waits for a response start, kind is serial, both queues
//   are empty.
//   Stall: when pop is held low, the result queue, the multiply stage and
//   the QUEUE_DEPTH-entry word queue fill in turn, then full rises.
`default_nettype none

module crc8_word_response_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               first_byte_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             data_word_o,
  output logic [1:0]              word_index_o,
  output logic                    crc_ok_o,
  output logic                    last_word_o,
  output logic signed [16:0]      scaled_value_o,
  output logic                    data_ready_o
);

  localparam int RecW = $bits(crc8wd_pkg::rec_t);
  localparam int ResW = $bits(crc8wd_pkg::res_t);

  logic [1:0]       kind_q, kind_d;
  logic             accept;
  logic             rec_valid;
  crc8wd_pkg::rec_t rec_in, rec_out;
  logic [RecW-1:0]  rec_rdata;
  logic             word_empty, rec_pop;
  logic             res_full, res_push;
  crc8wd_pkg::res_t res_in, res_out;
  logic [ResW-1:0]  res_rdata;

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == crc8wd_pkg::RegKind) ? {30'd0, kind_q} : 32'd0;

  always_comb begin
    kind_d = kind_q;
    if (psel && penable && pwrite && pready && paddr[2] == crc8wd_pkg::RegKind) begin
      kind_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= crc8wd_pkg::KindSerial;
    end else begin
      kind_q <= kind_d;
    end
  end

  assign accept = push && !full;

  crc8wd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_q),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .first_byte_i (first_byte_i),
    .rec_valid_o  (rec_valid),
    .rec_o        (rec_in)
  );

  crc8wd_fifo #(
    .WIDTH (RecW),
    .DEPTH (QUEUE_DEPTH)
  ) u_word_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .wdata_i (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .rdata_o (rec_rdata),
    .empty_o (word_empty)
  );

  assign rec_out = crc8wd_pkg::rec_t'(rec_rdata);

  crc8wd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!word_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  crc8wd_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out        = crc8wd_pkg::res_t'(res_rdata);
  assign data_word_o    = res_out.data_word;
  assign word_index_o   = res_out.word_index;
  assign crc_ok_o       = res_out.crc_ok;
  assign last_word_o    = res_out.last_word;
  assign scaled_value_o = res_out.scaled_value;
  assign data_ready_o   = res_out.data_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/crc8wd_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on crc8_word_response_deframer ports only.
`default_nettype none

module crc8wd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic [15:0]        data_word_o,
  input wire logic [1:0]         word_index_o,
  input wire logic               crc_ok_o,
  input wire logic               last_word_o,
  input wire logic signed [16:0] scaled_value_o,
  input wire logic               data_ready_o
);

  // Queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !crc_ok_o) |-> (last_word_o && scaled_value_o == 17'sd0 && !data_ready_o))
    else $error("CRC failure result malformed");

  // A status word always ends its response
  a_ready_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_ready_o) |-> (crc_ok_o && last_word_o))
    else $error("data-ready flag on a word other than a final status word");

  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_word_o) |-> (crc_ok_o && word_index_o != 2'd2 && word_index_o != 2'd3))
    else $error("response not ended at its final word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_word_o) && $stable(word_index_o)))
    else $error("waiting result changed while not popped");

endmodule

bind crc8_word_response_deframer crc8wd_checker u_crc8wd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .data_word_o    (data_word_o),
  .word_index_o   (word_index_o),
  .crc_ok_o       (crc_ok_o),
  .last_word_o    (last_word_o),
  .scaled_value_o (scaled_value_o),
  .data_ready_o   (data_ready_o)
);

`default_nettype wire
